[sv/fir24_pkg.sv]
// ----------------------------------------------------------------------------
// fir24_pkg
// Shared constants, types and the coefficient table of the 24-tap left-channel
// FIR with bypass mode.
// ----------------------------------------------------------------------------
package fir24_pkg;

  localparam int TAPS_DEF         = 24;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int COEF_W     = 16;
  localparam int COEF_IDX_W = 7;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_FILTER = 2'd1,
    MODE_BYPASS = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MAC  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // symmetric low-pass taps; zero past the table
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    unique case (idx)
      7'd0, 7'd23:  c = -16'sd39;
      7'd1, 7'd22:  c =  16'sd159;
      7'd2, 7'd21:  c = -16'sd36;
      7'd3, 7'd20:  c = -16'sd337;
      7'd4, 7'd19:  c =  16'sd486;
      7'd5, 7'd18:  c =  16'sd185;
      7'd6, 7'd17:  c = -16'sd1205;
      7'd7, 7'd16:  c =  16'sd947;
      7'd8, 7'd15:  c =  16'sd1413;
      7'd9, 7'd14:  c = -16'sd3745;
      7'd10, 7'd13: c =  16'sd1289;
      7'd11, 7'd12: c =  16'sd17300;
      default:      c =  '0;
    endcase
    return c;
  endfunction

endpackage

[sv/fir_24tap_with_bypass_mode.sv]
// ----------------------------------------------------------------------------
// fir_24tap_with_bypass_mode
// Left-channel direct-form FIR over a circular delay line held in a RAM,
// with a sticky filter/bypass mode; right channel passes straight through.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one stereo frame per word:
//   left and right samples plus the two button levels. Output channel
//   (out_valid / out_stall) returns one word per frame: left_out, right_out.
//   Every frame is written into the delay-line RAM whatever the mode.
//   Bypass frames go from acceptance through the DONE state to the output register.
//   Filter frames: one RAM read and one multiply per tap through a 3-stage
//   read / multiply / accumulate path, then through DONE to the output register;
//   the shared multiplier and one-read RAM port make the taps go one at a time.
//   One frame is in flight at a time; in_stall is high while it is worked on.
//   The finished word sits in an output register, so the next frame is taken
//   while it waits. A stalled result holds until out_stall drops.
//   Reset clears the per-entry valid bits (delay line reads as zero), sets
//   the mode to MODE_INIT (acts as bypass), clears out_valid. No clearing pass.
// ----------------------------------------------------------------------------
module fir_24tap_with_bypass_mode #(
  parameter int TAPS         = fir24_pkg::TAPS_DEF,
  parameter int SAMPLE_WIDTH = fir24_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] in_right_sample,
  input  logic                           in_filter_button,
  input  logic                           in_bypass_button,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0] out_right_out
);

  localparam int AW     = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int PROD_W = SAMPLE_WIDTH + fir24_pkg::COEF_W;
  localparam int SUM_W  = PROD_W + AW;
  localparam int ACC_W  = (SUM_W > 2 * SAMPLE_WIDTH - 1) ? SUM_W : 2 * SAMPLE_WIDTH - 1;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);

  fir24_pkg::state_t state_r, state_nxt;
  fir24_pkg::mode_t  mode_r, mode_nxt;

  logic [SAMPLE_WIDTH-1:0] mem [TAPS];
  logic [TAPS-1:0]         vld_r;
  logic [SAMPLE_WIDTH-1:0] mem_q_r;

  logic [AW-1:0] head_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] cnt_r;
  logic          iss_done_r;

  logic          s1_vld_r;
  logic          s1_tap0_r;
  logic          s1_hit_r;
  logic [AW-1:0] s1_idx_r;
  logic          s2_vld_r;

  logic signed [SAMPLE_WIDTH-1:0]       left_r;
  logic signed [SAMPLE_WIDTH-1:0]       right_r;
  logic                                 filt_r;
  logic signed [PROD_W-1:0]             prod_r;
  logic signed [ACC_W-1:0]              acc_r;
  logic signed [SAMPLE_WIDTH-1:0]       tap_val;
  logic signed [fir24_pkg::COEF_W-1:0]  coef_val;

  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_left_r;
  logic signed [SAMPLE_WIDTH-1:0] out_right_r;

  logic in_accept;
  logic out_load;
  logic issue;

  assign in_stall  = (state_r != fir24_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == fir24_pkg::ST_DONE) && (!out_valid_r || !out_stall);
  assign issue     = (state_r == fir24_pkg::ST_MAC) && !iss_done_r;

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  always_comb begin
    mode_nxt = mode_r;
    priority if (in_bypass_button) begin
      mode_nxt = fir24_pkg::MODE_BYPASS;
    end else if (in_filter_button) begin
      mode_nxt = fir24_pkg::MODE_FILTER;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fir24_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_nxt = (mode_nxt == fir24_pkg::MODE_FILTER) ? fir24_pkg::ST_MAC
                                                            : fir24_pkg::ST_DONE;
        end
      end
      fir24_pkg::ST_MAC: begin
        if (iss_done_r && !s1_vld_r && !s2_vld_r) begin
          state_nxt = fir24_pkg::ST_DONE;
        end
      end
      fir24_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = fir24_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fir24_pkg::ST_IDLE;
    endcase
  end

  // tap 0 is the word just written: forwarded from left_r
  assign tap_val  = s1_tap0_r ? left_r : (s1_hit_r ? $signed(mem_q_r) : '0);
  assign coef_val = fir24_pkg::coef_at(fir24_pkg::COEF_IDX_W'(s1_idx_r));

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fir24_pkg::ST_IDLE;
      mode_r      <= fir24_pkg::MODE_INIT;
      vld_r       <= '0;
      head_r      <= '0;
      iss_done_r  <= 1'b1;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (in_accept) begin
        mode_r         <= mode_nxt;
        vld_r[head_r]  <= 1'b1;
        head_r         <= (head_r == LAST) ? '0 : head_r + 1'b1;
        iss_done_r     <= (mode_nxt != fir24_pkg::MODE_FILTER);
      end else if (issue && cnt_r == LAST) begin
        iss_done_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // delay-line RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (in_accept) begin
      mem[head_r] <= in_left_sample;
    end
    mem_q_r <= mem[rd_ptr_r];
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_r   <= in_left_sample;
      right_r  <= in_right_sample;
      filt_r   <= (mode_nxt == fir24_pkg::MODE_FILTER);
      cnt_r    <= '0;
      rd_ptr_r <= (head_r == '0) ? LAST : head_r - 1'b1;
      acc_r    <= '0;
    end else begin
      if (issue) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r != '0) begin
          rd_ptr_r <= (rd_ptr_r == '0) ? LAST : rd_ptr_r - 1'b1;
        end
      end
      if (s2_vld_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    s1_tap0_r <= (cnt_r == '0);
    s1_hit_r  <= vld_r[rd_ptr_r];
    s1_idx_r  <= cnt_r;
    prod_r    <= PROD_W'(tap_val) * PROD_W'(coef_val);
    if (out_load) begin
      out_left_r  <= filt_r ? acc_r[2*SAMPLE_WIDTH-2:SAMPLE_WIDTH-1] : left_r;
      out_right_r <= right_r;
    end
  end

endmodule
